// ----- design/oss_pkg.sv -----
// Package for the ordered selection set: sizes, command codes, cell op codes
// and the structs passed along the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oss_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Command codes on in_func; six and seven are no-ops
  typedef enum logic [2:0] {
    F_TOGGLE = 3'd0,
    F_REMAP  = 3'd1,
    F_SWAP   = 3'd2,
    F_DELETE = 3'd3,
    F_CLEAR  = 3'd4,
    F_QUERY  = 3'd5
  } func_t;

  // Operation broadcast to every cell in a cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_TOGGLE,
    OP_MARK,
    OP_REMAP,
    OP_SWAP,
    OP_RENUM,
    OP_CLEAR,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
  } cell_cmd_t;

  // Contents of one cell, seen by its lower neighbor
  typedef struct packed {
    logic [IDX_W-1:0] val;
    logic             vld;
    logic             del;
  } cell_data_t;

  // Flags rippling from cell 0 upward
  typedef struct packed {
    logic found;   // a valid match at or below
    logic second;  // a second valid match at or below
    logic hole;    // a valid entry marked for removal at or below
  } chain_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COMPACT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/oss_cell.sv -----
// One cell of the selection list: holds one entry, its valid and remove marks.
// Depends on oss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oss_cell
  import oss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_cmd_t  cmd,
  input  wire cell_data_t up,        // upper neighbor
  input  wire logic       prev_vld,  // lower neighbor valid, 1 for cell 0
  input  wire chain_t     chain_in,
  output chain_t          chain_out,
  output cell_data_t      cur
);

  logic [IDX_W-1:0] val_r, val_nxt;
  logic             vld_r, vld_nxt;
  logic             del_r, del_nxt;
  logic             match_a;
  logic             match_b;

  assign match_a = vld_r && (val_r == cmd.a);
  assign match_b = vld_r && (val_r == cmd.b);

  assign chain_out.found  = chain_in.found | match_a;
  assign chain_out.second = chain_in.second | (chain_in.found & match_a);
  assign chain_out.hole   = chain_in.hole | (vld_r & del_r);

  assign cur.val = val_r;
  assign cur.vld = vld_r;
  assign cur.del = del_r;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    del_nxt = del_r;
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_TOGGLE: begin
        // first match only; tail cell appends when nothing matched below
        del_nxt = match_a & ~chain_in.found;
        if (!vld_r && prev_vld && !chain_in.found) begin
          val_nxt = cmd.a;
          vld_nxt = 1'b1;
        end
      end
      OP_MARK: begin
        del_nxt = match_a;
      end
      OP_REMAP: begin
        del_nxt = 1'b0;
        if (match_a) val_nxt = cmd.b;
      end
      OP_SWAP: begin
        del_nxt = 1'b0;
        if (match_a) begin
          val_nxt = cmd.b;
        end else if (match_b) begin
          val_nxt = cmd.a;
        end
      end
      OP_RENUM: begin
        del_nxt = match_a;
        if (vld_r && (val_r > cmd.a)) val_nxt = val_r - IDX_W'(1);
      end
      OP_CLEAR: begin
        vld_nxt = 1'b0;
        del_nxt = 1'b0;
      end
      OP_SHIFT: begin
        // everything from the lowest hole upward moves down one place
        if (chain_out.hole) begin
          val_nxt = up.val;
          vld_nxt = up.vld;
          del_nxt = up.del;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
      del_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      del_r <= del_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/ordered_selection_set.sv -----
// Ordered selection set: a list of up to DEPTH indices kept in a row of cells,
// one entry per cell, with a small sequencer in front. Every command is applied
// to all cells at once; removed entries are then squeezed out one per cycle by
// shifting the cells above the lowest hole down one place. Query, swap, clear and
// a toggle that appends remove no entries. The next input word is taken only once
// the result word of the last one is loaded, so a new word is not taken before the
// last one is through; a result held by a low out_ready stretches this by the
// stall.
// Depends on oss_pkg and oss_cell.
`timescale 1ns / 1ps
`default_nettype none

module ordered_selection_set
  import oss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_func,
  input  wire logic [IDX_W-1:0] in_index_a,
  input  wire logic [IDX_W-1:0] in_index_b,
  input  wire logic             in_remove_flag,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_selected,
  output logic [CNT_W-1:0]      out_entry_count,
  output logic                  out_full_flag
);

  state_t           state_r, state_nxt;
  logic [2:0]       func_r;
  logic [IDX_W-1:0] a_r;
  logic [IDX_W-1:0] b_r;
  logic             rm_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             sel_r, sel_nxt;
  logic             full_r, full_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_sel_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_full_r;
  logic             load_out;

  cell_cmd_t        cmd;
  cell_data_t       dat [DEPTH];
  chain_t           chn [DEPTH+1];
  logic [DEPTH-1:0] vld_vec;
  logic             found;
  logic             hole_any;
  logic             at_full;

  assign chn[0]   = '0;
  assign found    = chn[DEPTH].found;
  assign hole_any = chn[DEPTH].hole;
  assign at_full  = (count_r == CNT_W'(DEPTH));

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_data_t up_d;
      logic       prev_v;
      if (gi == DEPTH - 1) begin : g_top
        assign up_d = '0;
      end else begin : g_mid
        assign up_d = dat[gi+1];
      end
      if (gi == 0) begin : g_bot
        assign prev_v = 1'b1;
      end else begin : g_up
        assign prev_v = dat[gi-1].vld;
      end
      oss_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .up        (up_d),
        .prev_vld  (prev_v),
        .chain_in  (chn[gi]),
        .chain_out (chn[gi+1]),
        .cur       (dat[gi])
      );
      assign vld_vec[gi] = dat[gi].vld;
    end
  endgenerate

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_selected    = out_sel_r;
  assign out_entry_count = out_cnt_r;
  assign out_full_flag   = out_full_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sel_nxt       = sel_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    load_out      = 1'b0;
    cmd.op        = OP_HOLD;
    cmd.a         = a_r;
    cmd.b         = b_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        sel_nxt   = 1'b0;
        full_nxt  = 1'b0;
        state_nxt = S_COMPACT;
        unique case (func_r)
          F_TOGGLE: begin
            cmd.op = OP_TOGGLE;
            if (found) begin
              sel_nxt = chn[DEPTH].second;
            end else if (!at_full) begin
              sel_nxt   = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              full_nxt = 1'b1;
            end
          end
          F_REMAP:  cmd.op = rm_r ? OP_MARK : OP_REMAP;
          F_SWAP:   cmd.op = OP_SWAP;
          F_DELETE: cmd.op = OP_RENUM;
          F_CLEAR: begin
            cmd.op    = OP_CLEAR;
            count_nxt = '0;
          end
          F_QUERY:  sel_nxt = found;
          default: begin
          end
        endcase
      end
      S_COMPACT: begin
        if (hole_any) begin
          cmd.op    = OP_SHIFT;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      a_r    <= in_index_a;
      b_r    <= in_index_b;
      rm_r   <= in_remove_flag;
    end
    sel_r  <= sel_nxt;
    full_r <= full_nxt;
    if (load_out) begin
      out_sel_r  <= sel_r;
      out_cnt_r  <= count_r;
      out_full_r <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // count never exceeds the cell row
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // between words the valid cells match the count and no removal is pending
  a_idle_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ($countones(vld_vec) == 32'(count_r)) && !hole_any)
    else $error("cell row out of step with count");

  // each compaction step drops exactly one entry
  a_compact_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT && hole_any) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("compaction step miscounted");

  // valid cells stay packed at the bottom of the row
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> ((vld_vec & (vld_vec + DEPTH'(1))) == '0))
    else $error("valid cells not contiguous");

endmodule

`default_nettype wire
